// ===== rtl/lgs_pkg.sv =====
// Shared types, constants and controller/datapath interface for the 3D Laplace solver.
package lgs_pkg;

  localparam int DEF_MAX_NODES = 4096;
  localparam int DEF_MAX_SIDE  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POT_W      = 32;
  localparam int COEF_W     = 16;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;
  localparam int NIDX_W     = 12;
  localparam int GRID_W     = 5;
  localparam int CNT_W      = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } lgs_op_t;

  localparam logic [KIND_W-1:0] KIND_FIXED = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS = 3'd7;

  localparam logic [GRID_W-1:0] RST_GRID       = 5'd16;
  localparam logic [COEF_W-1:0] RST_COEF_XY    = 16'd10923;
  localparam logic [COEF_W-1:0] RST_COEF_Z     = 16'd10922;
  localparam logic [CNT_W-1:0]  RST_TOLERANCE  = 16'd1;
  localparam logic [CNT_W-1:0]  RST_MAX_SWEEPS = 16'd20000;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;
    logic rd_issue;
    logic res_push;
    logic res_pot;
    logic sol_init;
    logic sweep_init;
    logic self_rd;
    logic node_cap;
    logic nb_rd;
    logic nb_mul;
    logic nb_acc;
    logic node_wr;
    logic node_next;
    logic sweep_end;
    logic sol_fin;
    logic fin_conv;
  } lgs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;
    logic max_zero;
    logic node_skip;
    logic nb_last;
    logic last_node;
    logic conv_ok;
    logic sweep_lim;
  } lgs_stat_t;

endpackage

// ===== rtl/lgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ===== rtl/lgs_ctrl.sv =====
// Sequencer for load, read and Gauss-Seidel solve requests.
module lgs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [lgs_pkg::OP_W-1:0] in_op,
  input  logic                   out_ready,
  output logic                   in_ready,
  output lgs_pkg::lgs_cmd_t      cmd,
  input  lgs_pkg::lgs_stat_t     stat
);
  import lgs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_START, S_SELF_RD, S_SELF_CHK, S_NB_RD, S_NB_MUL,
    S_NB_ACC, S_WR, S_NEXT, S_SW_END, S_SW_CHK, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && (!stat.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (lgs_op_t'(in_op))
            OP_LOAD: begin
              cmd.load_wr  = 1'b1;
              cmd.res_push = 1'b1;
            end
            OP_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD_WAIT;
            end
            OP_SOLVE: begin
              cmd.sol_init = 1'b1;
              state_nxt    = S_START;
            end
            default: cmd.res_push = 1'b1;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.res_push = 1'b1;
        cmd.res_pot  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_START: begin
        if (stat.max_zero) begin
          cmd.sol_fin = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SELF_RD;
        end
      end
      S_SELF_RD: begin
        cmd.self_rd = 1'b1;
        state_nxt   = S_SELF_CHK;
      end
      S_SELF_CHK: begin
        cmd.node_cap = 1'b1;
        state_nxt    = stat.node_skip ? S_NEXT : S_NB_RD;
      end
      S_NB_RD: begin
        cmd.nb_rd = 1'b1;
        state_nxt = S_NB_MUL;
      end
      S_NB_MUL: begin
        cmd.nb_mul = 1'b1;
        state_nxt  = S_NB_ACC;
      end
      S_NB_ACC: begin
        cmd.nb_acc = 1'b1;
        state_nxt  = stat.nb_last ? S_WR : S_NB_RD;
      end
      S_WR: begin
        cmd.node_wr = 1'b1;
        state_nxt   = S_NEXT;
      end
      S_NEXT: begin
        cmd.node_next = 1'b1;
        state_nxt     = stat.last_node ? S_SW_END : S_SELF_RD;
      end
      S_SW_END: begin
        cmd.sweep_end = 1'b1;
        state_nxt     = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (stat.conv_ok || stat.sweep_lim) begin
          cmd.sol_fin  = 1'b1;
          cmd.fin_conv = stat.conv_ok;
          state_nxt    = S_FIN;
        end else begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SELF_RD;
        end
      end
      S_FIN: begin
        cmd.res_push = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== rtl/lgs_dp.sv =====
// Datapath: config registers, node stores, grid walk, stencil arithmetic, result register.
module lgs_dp #(
  parameter int MAX_NODES = lgs_pkg::DEF_MAX_NODES,
  parameter int MAX_SIDE  = lgs_pkg::DEF_MAX_SIDE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [lgs_pkg::NIDX_W-1:0]     in_node_index,
  input  logic [lgs_pkg::KIND_W-1:0]     in_node_kind,
  input  logic signed [lgs_pkg::POT_W-1:0] in_boundary_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [lgs_pkg::POT_W-1:0] out_potential,
  output logic                           out_converged,
  output logic [lgs_pkg::CNT_W-1:0]      out_sweeps_used,
  input  lgs_pkg::lgs_cmd_t              cmd,
  output lgs_pkg::lgs_stat_t             stat
);
  import lgs_pkg::*;

  localparam int AW  = $clog2(MAX_NODES);
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int IW  = 3 * SW;
  localparam int PW  = POT_W + COEF_W + 1;
  localparam int TW  = POT_W + 1;
  localparam int ACW = POT_W + 4;

  // configuration
  logic [GRID_W-1:0] grid_x_r, grid_y_r, grid_z_r;
  logic [COEF_W-1:0] coef_x_r, coef_y_r, coef_z_r;
  logic [CNT_W-1:0]  tol_r, max_sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= RST_GRID;
      grid_y_r <= RST_GRID;
      grid_z_r <= RST_GRID;
      coef_x_r <= RST_COEF_XY;
      coef_y_r <= RST_COEF_XY;
      coef_z_r <= RST_COEF_Z;
      tol_r    <= RST_TOLERANCE;
      max_sw_r <= RST_MAX_SWEEPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X:     grid_x_r <= cfg_data[GRID_W-1:0];
        REG_GRID_Y:     grid_y_r <= cfg_data[GRID_W-1:0];
        REG_GRID_Z:     grid_z_r <= cfg_data[GRID_W-1:0];
        REG_COEF_X:     coef_x_r <= cfg_data;
        REG_COEF_Y:     coef_y_r <= cfg_data;
        REG_COEF_Z:     coef_z_r <= cfg_data;
        REG_TOLERANCE:  tol_r    <= cfg_data;
        REG_MAX_SWEEPS: max_sw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] clamp_side(input logic [GRID_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) r = SW'(1);
    else if (int'(v) > MAX_SIDE) r = SW'(MAX_SIDE);
    else r = SW'(v);
    return r;
  endfunction

  // grid walk state
  logic [SW-1:0]   nx_r, ny_r, nz_r, i_r, j_r, k_r;
  logic [2*SW-1:0] sx_r;
  logic [IW-1:0]   idx_r;
  logic [2:0]      d_r;
  logic [CNT_W-1:0] done_r;
  logic            conv_flag_r;
  logic [CNT_W-1:0] sweep_cnt_r;
  logic [TW-1:0]   maxdiff_r;
  logic signed [POT_W-1:0] old_r;
  logic signed [ACW-1:0]   acc_r;
  logic signed [TW-1:0]    prod_r;
  logic            rd_oob_r;

  logic [KIND_W-1:0] kind_rdata;
  logic [POT_W-1:0]  pot_rdata;
  logic [AW-1:0]     raddr, pot_waddr;
  logic [POT_W-1:0]  pot_wdata;
  logic              pot_we;

  logic in_oob, idx_oob;
  assign in_oob  = 32'(in_node_index) >= 32'(MAX_NODES);
  assign idx_oob = 32'(idx_r) >= 32'(MAX_NODES);

  // neighbour address
  logic          nb_pres, nb_plus;
  logic [IW-1:0] nb_off;
  logic [IW:0]   nb_n;
  logic [AW-1:0] nb_addr;
  logic [COEF_W-1:0] nb_coef;

  always_comb begin
    nb_pres = 1'b0;
    nb_plus = 1'b1;
    nb_off  = IW'(1);
    case (d_r)
      3'd0: begin nb_pres = (SW'(i_r + 1'b1) < nx_r); nb_off = IW'(sx_r); end
      3'd1: begin nb_pres = (i_r != '0); nb_plus = 1'b0; nb_off = IW'(sx_r); end
      3'd2: begin nb_pres = (SW'(j_r + 1'b1) < ny_r); nb_off = IW'(nz_r); end
      3'd3: begin nb_pres = (j_r != '0); nb_plus = 1'b0; nb_off = IW'(nz_r); end
      3'd4: begin nb_pres = (SW'(k_r + 1'b1) < nz_r); end
      3'd5: begin nb_pres = (k_r != '0); nb_plus = 1'b0; end
      default: ;
    endcase
    nb_n = nb_plus ? ({1'b0, idx_r} + {1'b0, nb_off}) : ({1'b0, idx_r} - {1'b0, nb_off});
    nb_addr = (nb_pres && (32'(nb_n) < 32'(MAX_NODES))) ? AW'(nb_n) : AW'(idx_r);
    case (d_r[2:1])
      2'd0:    nb_coef = coef_x_r;
      2'd1:    nb_coef = coef_y_r;
      default: nb_coef = coef_z_r;
    endcase
  end

  always_comb begin
    if (cmd.self_rd)    raddr = AW'(idx_r);
    else if (cmd.nb_rd) raddr = nb_addr;
    else                raddr = AW'(in_node_index);
  end

  // stencil arithmetic
  logic signed [PW-1:0]    prod_full;
  logic signed [POT_W-1:0] nv;
  logic signed [TW-1:0]    diff;
  logic [TW-1:0]           adiff;

  assign prod_full = $signed(pot_rdata) * $signed({1'b0, nb_coef});

  always_comb begin
    if (acc_r > $signed(ACW'(33'sh0_7FFF_FFFF)))       nv = 32'sh7FFF_FFFF;
    else if (acc_r < $signed({{(ACW-POT_W){1'b1}}, 32'h8000_0000})) nv = 32'sh8000_0000;
    else nv = POT_W'(acc_r);
    diff  = TW'(nv) - TW'(old_r);
    adiff = diff[TW-1] ? TW'(-diff) : TW'(diff);
  end

  assign pot_we    = (cmd.load_wr && !in_oob) || cmd.node_wr;
  assign pot_waddr = cmd.node_wr ? AW'(idx_r) : AW'(in_node_index);
  assign pot_wdata = cmd.node_wr ? nv :
                     ((in_node_kind == KIND_FIXED) ? in_boundary_value : '0);

  lgs_ram #(.WIDTH(KIND_W), .DEPTH(MAX_NODES)) u_kind_ram (
    .clk     (clk),
    .we      (cmd.load_wr && !in_oob),
    .waddr   (AW'(in_node_index)),
    .wdata   (in_node_kind),
    .raddr   (raddr),
    .rdata_r (kind_rdata)
  );

  lgs_ram #(.WIDTH(POT_W), .DEPTH(MAX_NODES)) u_pot_ram (
    .clk     (clk),
    .we      (pot_we),
    .waddr   (pot_waddr),
    .wdata   (pot_wdata),
    .raddr   (raddr),
    .rdata_r (pot_rdata)
  );

  logic last_k, last_j, last_i;
  assign last_k = (SW'(k_r + 1'b1) == nz_r);
  assign last_j = (SW'(j_r + 1'b1) == ny_r);
  assign last_i = (SW'(i_r + 1'b1) == nx_r);

  always_ff @(posedge clk) begin
    if (cmd.sol_init) begin
      nx_r <= clamp_side(grid_x_r);
      ny_r <= clamp_side(grid_y_r);
      nz_r <= clamp_side(grid_z_r);
      sx_r <= clamp_side(grid_y_r) * clamp_side(grid_z_r);
    end
    if (cmd.sweep_init) begin
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      idx_r     <= '0;
      maxdiff_r <= '0;
    end else if (cmd.node_next) begin
      idx_r <= idx_r + 1'b1;
      if (!last_k) begin
        k_r <= k_r + 1'b1;
      end else begin
        k_r <= '0;
        if (!last_j) begin
          j_r <= j_r + 1'b1;
        end else begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end
      end
    end else if (cmd.node_wr) begin
      if (adiff > maxdiff_r) maxdiff_r <= adiff;
    end
    if (cmd.node_cap) begin
      old_r <= pot_rdata;
      acc_r <= '0;
      d_r   <= '0;
    end else if (cmd.nb_acc) begin
      acc_r <= acc_r + ACW'(prod_r);
      d_r   <= d_r + 1'b1;
    end
    if (cmd.nb_mul) begin
      prod_r <= prod_full[PW-1:COEF_W];
    end
    if (cmd.rd_issue) begin
      rd_oob_r <= in_oob;
    end
  end

  // solve bookkeeping and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      conv_flag_r <= 1'b0;
      sweep_cnt_r <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.sol_init)       done_r <= '0;
      else if (cmd.sweep_end) done_r <= done_r + 1'b1;
      if (cmd.sol_fin) begin
        conv_flag_r <= cmd.fin_conv;
        sweep_cnt_r <= done_r;
      end
      if (cmd.res_push)       out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      out_potential   <= (cmd.res_pot && !rd_oob_r) ? pot_rdata : '0;
      out_converged   <= conv_flag_r;
      out_sweeps_used <= sweep_cnt_r;
    end
  end

  assign stat.out_valid = out_valid;
  assign stat.max_zero  = (max_sw_r == '0);
  assign stat.node_skip = idx_oob || (kind_rdata == KIND_FIXED);
  assign stat.nb_last   = (d_r == 3'd5);
  assign stat.last_node = last_k && last_j && last_i;
  assign stat.conv_ok   = maxdiff_r < TW'(tol_r);
  assign stat.sweep_lim = (done_r == max_sw_r);
endmodule

// ===== rtl/laplace_gauss_seidel_3d.sv =====
// Load request: result in the next cycle, one load per cycle while out_ready is high.
// Read request: RAM read then result register; no new request is taken until it is done.
// Solve request: each non-fixed node is read, then its neighbours are read, scaled
//   and summed one by one (one memory read port walks the node and its six neighbours)
//   before write-back; fixed nodes are skipped; busy until the solve result is delivered.
// Reset (rst_n, synchronous, active low): config registers to defaults, converged and
//   sweep count cleared; node memories are not cleared and must be loaded before use.
module laplace_gauss_seidel_3d #(
  parameter int MAX_NODES = lgs_pkg::DEF_MAX_NODES,
  parameter int MAX_SIDE  = lgs_pkg::DEF_MAX_SIDE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lgs_pkg::OP_W-1:0]         in_op,
  input  logic [lgs_pkg::NIDX_W-1:0]       in_node_index,
  input  logic [lgs_pkg::KIND_W-1:0]       in_node_kind,
  input  logic signed [lgs_pkg::POT_W-1:0] in_boundary_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [lgs_pkg::POT_W-1:0] out_potential,
  output logic                             out_converged,
  output logic [lgs_pkg::CNT_W-1:0]        out_sweeps_used
);
  import lgs_pkg::*;

  lgs_cmd_t  cmd;
  lgs_stat_t stat;

  // Sequencer: decodes requests and steps the sweep node by node.
  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: node memories, stencil multiply-accumulate, convergence tracking.
  lgs_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_SIDE  (MAX_SIDE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_node_index     (in_node_index),
    .in_node_kind      (in_node_kind),
    .in_boundary_value (in_boundary_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_potential     (out_potential),
    .out_converged     (out_converged),
    .out_sweeps_used   (out_sweeps_used),
    .cmd               (cmd),
    .stat              (stat)
  );
endmodule
